/* hw/rtl/cbq_pkg.sv */
`default_nettype none

package cbq_pkg;

   // Sizing
   localparam int MAX_STAGES      = 16;
   localparam int COEFS_PER_STAGE = 5;
   localparam int COEF_DEPTH      = MAX_STAGES * COEFS_PER_STAGE;
   localparam int COEF_AW         = $clog2(COEF_DEPTH);
   localparam int STAGE_W         = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int CNT_W           = $clog2(MAX_STAGES + 1);

   // Field widths
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int CFG_W       = 5;
   localparam int STAGE_IDX_W = 4;
   localparam int COEF_IDX_W  = 3;
   localparam int HIST_W      = 4 * SAMPLE_W;

   // Arithmetic: Q2.30 x Q1.23 products, five of them summed exactly
   localparam int PROD_W     = COEF_W + SAMPLE_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 30;
   localparam int SHIFTED_W  = ACC_W - FRAC_SHIFT;

   // Request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   // Sequencer steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_ACCEPT = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ROW    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_X  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_X1 = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MUL_X2 = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_Y1 = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MUL_Y2 = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DRAIN  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd9;

   // Jump conditions
   localparam logic [1:0] COND_GOTO   = 2'd0;
   localparam logic [1:0] COND_ACCEPT = 2'd1;
   localparam logic [1:0] COND_LOOP   = 2'd2;
   localparam logic [1:0] COND_EMIT   = 2'd3;

   // Multiplier operand select
   localparam logic [2:0] OPND_X  = 3'd0;
   localparam logic [2:0] OPND_X1 = 3'd1;
   localparam logic [2:0] OPND_X2 = 3'd2;
   localparam logic [2:0] OPND_Y1 = 3'd3;
   localparam logic [2:0] OPND_Y2 = 3'd4;

   // Accumulator operations
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   typedef struct packed {
      logic       mul_en;
      logic [1:0] acc_op;
   } mac_ctrl_type;

   typedef struct packed {
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
      logic              coef_rd;
      logic              hist_rd;
      logic [2:0]        opnd_sel;
      mac_ctrl_type      mac;
      logic              finish;
   } ucode_type;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc.cond       = COND_GOTO;
      uc.target     = STEP_ACCEPT;
      uc.coef_rd    = 1'b0;
      uc.hist_rd    = 1'b0;
      uc.opnd_sel   = OPND_X;
      uc.mac.mul_en = 1'b0;
      uc.mac.acc_op = ACC_HOLD;
      uc.finish     = 1'b0;
      case (step)
         STEP_ACCEPT: begin
            uc.cond   = COND_ACCEPT;
            uc.target = STEP_EMIT;
         end
         STEP_ROW: begin
            uc.target  = STEP_MUL_X;
            uc.coef_rd = 1'b1;
            uc.hist_rd = 1'b1;
         end
         STEP_MUL_X: begin
            uc.target     = STEP_MUL_X1;
            uc.coef_rd    = 1'b1;
            uc.opnd_sel   = OPND_X;
            uc.mac.mul_en = 1'b1;
         end
         STEP_MUL_X1: begin
            uc.target     = STEP_MUL_X2;
            uc.coef_rd    = 1'b1;
            uc.opnd_sel   = OPND_X1;
            uc.mac.mul_en = 1'b1;
            uc.mac.acc_op = ACC_LOAD;
         end
         STEP_MUL_X2: begin
            uc.target     = STEP_MUL_Y1;
            uc.coef_rd    = 1'b1;
            uc.opnd_sel   = OPND_X2;
            uc.mac.mul_en = 1'b1;
            uc.mac.acc_op = ACC_ADD;
         end
         STEP_MUL_Y1: begin
            uc.target     = STEP_MUL_Y2;
            uc.coef_rd    = 1'b1;
            uc.opnd_sel   = OPND_Y1;
            uc.mac.mul_en = 1'b1;
            uc.mac.acc_op = ACC_ADD;
         end
         STEP_MUL_Y2: begin
            uc.target     = STEP_DRAIN;
            uc.opnd_sel   = OPND_Y2;
            uc.mac.mul_en = 1'b1;
            uc.mac.acc_op = ACC_SUB;
         end
         STEP_DRAIN: begin
            uc.target     = STEP_FINISH;
            uc.mac.acc_op = ACC_SUB;
         end
         STEP_FINISH: begin
            uc.cond   = COND_LOOP;
            uc.target = STEP_ROW;
            uc.finish = 1'b1;
         end
         STEP_EMIT: begin
            uc.cond   = COND_EMIT;
            uc.target = STEP_ACCEPT;
         end
         default: begin
            uc.cond   = COND_GOTO;
            uc.target = STEP_ACCEPT;
         end
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/cbq_ram.sv */
`default_nettype none

// Simple dual-port RAM, registered read
module cbq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/cbq_mac.sv */
`default_nettype none

// Shared multiply-accumulate with round half up and 24-bit saturation
module cbq_mac (
   input  wire logic                                 clock,
   input  wire cbq_pkg::mac_ctrl_type                ctrl,
   input  wire logic signed [cbq_pkg::COEF_W-1:0]    coef,
   input  wire logic signed [cbq_pkg::SAMPLE_W-1:0]  opnd,
   output logic signed      [cbq_pkg::SAMPLE_W-1:0]  result
);

   import cbq_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     acc_in;
   logic signed [ACC_W-1:0]     prod_ext;
   logic signed [ACC_W-1:0]     rounded;
   logic        [SHIFTED_W-1:0] shifted;
   logic        [SHIFTED_W-SAMPLE_W:0] upper;

   // Product register
   always_comb begin
      prod_in = prod_ff;
      if (ctrl.mul_en) begin
         prod_in = coef * opnd;
      end
   end

   // Accumulator
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      case (ctrl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Round to Q1.23 (floor of acc + half) and clamp
   assign rounded = acc_ff + ROUND_HALF;
   assign shifted = rounded[ACC_W-1:FRAC_SHIFT];
   assign upper   = shifted[SHIFTED_W-1:SAMPLE_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         result = shifted[SAMPLE_W-1:0];
      end else if (shifted[SHIFTED_W-1]) begin
         result = SAT_MIN;
      end else begin
         result = SAT_MAX;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/cascaded_biquad_equalizer_top.sv */
`default_nettype none

// Cascaded biquad equalizer, direct form I, up to MAX_STAGES sections.
// Request channel (req_*): each word either filters one Q1.23 sample
// (req_type = 0) or writes one Q2.30 coefficient (req_type = 1).
// Response channel (rsp_*): one word per filtered sample, none for writes.
// csr_write_en / csr_write_data set active_stages; write only while idle.
// active_stages is clamped to MAX_STAGES. Each stage takes eight steps of
// the microcoded sequencer around one shared 32x24 multiplier and one
// coefficient RAM. The next request is taken once the result is in the
// output register; coefficient writes are taken back to back while the
// sequencer waits in its accept step.
// A stalled response holds in the output register; the sequencer waits in
// its emit step only if a second result is ready before the first is taken.
// Reset (synchronous) clears the sequencer, active_stages and all filter
// history, and holds req_stall high; coefficients are undefined until written.
module cascaded_biquad_equalizer_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_type,
   input  wire logic signed [cbq_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic        [cbq_pkg::STAGE_IDX_W-1:0] req_stage_index,
   input  wire logic        [cbq_pkg::COEF_IDX_W-1:0]  req_coef_index,
   input  wire logic signed [cbq_pkg::COEF_W-1:0]      req_coef_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed      [cbq_pkg::SAMPLE_W-1:0]    rsp_filtered_sample,
   input  wire logic                                   csr_write_en,
   input  wire logic        [cbq_pkg::CFG_W-1:0]       csr_write_data
);

   import cbq_pkg::*;

   ucode_type uc;

   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [STAGE_W-1:0] stage_ff;
   logic [STAGE_W-1:0] stage_in;
   logic [COEF_AW-1:0] caddr_ff;
   logic [COEF_AW-1:0] caddr_in;
   logic [CFG_W-1:0]   active_ff;
   logic [CFG_W-1:0]   active_in;
   logic [MAX_STAGES-1:0] hvalid_ff;
   logic [MAX_STAGES-1:0] hvalid_in;
   logic               hok_ff;
   logic               hok_in;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] x_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_in;

   logic               req_fire;
   logic               sample_fire;
   logic [CNT_W-1:0]   n_eff;
   logic               last_stage;
   logic               out_free;

   logic               coef_wr_en;
   logic [COEF_AW-1:0] coef_wr_addr;
   logic signed [COEF_W-1:0] coef_rd_data;

   logic [HIST_W-1:0]  hist_rd_data;
   logic [HIST_W-1:0]  hist_wr_data;
   logic signed [SAMPLE_W-1:0] x1;
   logic signed [SAMPLE_W-1:0] x2;
   logic signed [SAMPLE_W-1:0] y1;
   logic signed [SAMPLE_W-1:0] y2;
   logic signed [SAMPLE_W-1:0] opnd;
   logic signed [SAMPLE_W-1:0] stage_y;

   // Current control word
   assign uc = ucode_rom(step_ff);

   // Request handshake
   assign req_stall   = reset || (uc.cond != COND_ACCEPT);
   assign req_fire    = req_valid && !req_stall;
   assign sample_fire = req_fire && (req_type == REQ_SAMPLE);

   // Stage count, clamped
   assign n_eff = (int'(active_ff) > MAX_STAGES) ? CNT_W'(MAX_STAGES) : CNT_W'(active_ff);
   assign last_stage = ((CNT_W'(stage_ff) + CNT_W'(1)) == n_eff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Step sequencing
   always_comb begin
      case (uc.cond)
         COND_GOTO: step_in = uc.target;
         COND_ACCEPT: begin
            if (sample_fire) begin
               step_in = (n_eff == '0) ? uc.target : step_ff + STEP_W'(1);
            end else begin
               step_in = step_ff;
            end
         end
         COND_LOOP: step_in = last_stage ? step_ff + STEP_W'(1) : uc.target;
         COND_EMIT: step_in = out_free ? uc.target : step_ff;
         default:   step_in = STEP_ACCEPT;
      endcase
   end

   // Coefficient store: write on request, stream reads during a stage
   assign coef_wr_en = req_fire && (req_type == REQ_COEF)
                       && (int'(req_coef_index) < COEFS_PER_STAGE)
                       && (int'(req_stage_index) < MAX_STAGES);
   assign coef_wr_addr = COEF_AW'(int'(req_stage_index) * COEFS_PER_STAGE
                                  + int'(req_coef_index));

   cbq_ram #(
      .WIDTH (COEF_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_en   (uc.coef_rd),
      .rd_addr (caddr_ff),
      .rd_data (coef_rd_data)
   );

   // History store: one row {y2, y1, x2, x1} per stage
   assign x1 = hok_ff ? hist_rd_data[0*SAMPLE_W +: SAMPLE_W] : '0;
   assign x2 = hok_ff ? hist_rd_data[1*SAMPLE_W +: SAMPLE_W] : '0;
   assign y1 = hok_ff ? hist_rd_data[2*SAMPLE_W +: SAMPLE_W] : '0;
   assign y2 = hok_ff ? hist_rd_data[3*SAMPLE_W +: SAMPLE_W] : '0;
   assign hist_wr_data = {y1, stage_y, x1, x_ff};

   cbq_ram #(
      .WIDTH (HIST_W),
      .DEPTH (MAX_STAGES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (uc.finish),
      .wr_addr (stage_ff),
      .wr_data (hist_wr_data),
      .rd_en   (uc.hist_rd),
      .rd_addr (stage_ff),
      .rd_data (hist_rd_data)
   );

   // Multiplier operand
   always_comb begin
      case (uc.opnd_sel)
         OPND_X:  opnd = x_ff;
         OPND_X1: opnd = x1;
         OPND_X2: opnd = x2;
         OPND_Y1: opnd = y1;
         OPND_Y2: opnd = y2;
         default: opnd = x_ff;
      endcase
   end

   cbq_mac u_mac (
      .clock  (clock),
      .ctrl   (uc.mac),
      .coef   (coef_rd_data),
      .opnd   (opnd),
      .result (stage_y)
   );

   // Datapath registers
   always_comb begin
      stage_in     = stage_ff;
      caddr_in     = caddr_ff;
      x_in         = x_ff;
      hok_in       = hok_ff;
      hvalid_in    = hvalid_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_en) begin
         active_in = csr_write_data;
      end
      if (sample_fire) begin
         stage_in = '0;
         caddr_in = '0;
         x_in     = req_sample;
      end
      if (uc.coef_rd) begin
         caddr_in = caddr_ff + COEF_AW'(1);
      end
      if (uc.hist_rd) begin
         hok_in = hvalid_ff[stage_ff];
      end
      if (uc.finish) begin
         x_in                = stage_y;
         stage_in            = stage_ff + STAGE_W'(1);
         hvalid_in[stage_ff] = 1'b1;
      end

      // Output register
      if ((uc.cond == COND_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = x_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_ACCEPT;
         active_ff    <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         active_ff    <= active_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stage_ff    <= stage_in;
      caddr_ff    <= caddr_in;
      x_ff        <= x_in;
      hok_ff      <= hok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/cbq_checker.sv */
`default_nettype none

// Port-level checks for the equalizer
module cbq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic req_type,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   import cbq_pkg::*;

   // Output register is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // A taken sample keeps the request side stalled while it is filtered
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == REQ_SAMPLE)) |=> req_stall)
      else $error("request taken while a sample is in flight");

   // No response word appears in the cycle after a request word is taken while the output register is empty
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared too early");

   // A stalled response word stays valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

endmodule

bind cascaded_biquad_equalizer_top cbq_checker u_cbq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_type  (req_type),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cbq_pkg::*;

   // Coefficient slots within a stage
   localparam logic [COEF_IDX_W-1:0] COEF_B0 = 3'd0;
   localparam logic [COEF_IDX_W-1:0] COEF_B1 = 3'd1;
   localparam logic [COEF_IDX_W-1:0] COEF_B2 = 3'd2;
   localparam logic [COEF_IDX_W-1:0] COEF_A1 = 3'd3;
   localparam logic [COEF_IDX_W-1:0] COEF_A2 = 3'd4;

   localparam logic signed [COEF_W-1:0]   Q_ONE   = 32'sh4000_0000;
   localparam logic signed [SAMPLE_W-1:0] SAT_HI  = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_LO  = 24'sh80_0000;
   localparam longint                     RND_HALF = 64'sd536870912;

   // Longest sample latency plus margin, used before csr writes and at the end
   localparam int DRAIN_CYCLES = 8 * MAX_STAGES + 12;

   typedef struct {
      logic                          kind;
      logic signed [SAMPLE_W-1:0]    audio;
      logic        [STAGE_IDX_W-1:0] stage;
      logic        [COEF_IDX_W-1:0]  coef_sel;
      logic signed [COEF_W-1:0]      coef_val;
   } eq_word_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic                          req_type        = REQ_SAMPLE;
   logic signed [SAMPLE_W-1:0]    req_sample      = '0;
   logic        [STAGE_IDX_W-1:0] req_stage_index = '0;
   logic        [COEF_IDX_W-1:0]  req_coef_index  = '0;
   logic signed [COEF_W-1:0]      req_coef_value  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b1;
   logic signed [SAMPLE_W-1:0]    rsp_filtered_sample;
   logic                          csr_write_en    = 1'b0;
   logic        [CFG_W-1:0]       csr_write_data  = '0;

   // Predictor state
   logic signed [COEF_W-1:0]   coef_mirror [COEF_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_x1 [MAX_STAGES];
   logic signed [SAMPLE_W-1:0] hist_x2 [MAX_STAGES];
   logic signed [SAMPLE_W-1:0] hist_y1 [MAX_STAGES];
   logic signed [SAMPLE_W-1:0] hist_y2 [MAX_STAGES];
   logic        [CFG_W-1:0]    stages_cfg;

   logic signed [SAMPLE_W-1:0] pending_outputs [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int samples_sent  = 0;
   int outputs_seen  = 0;
   int coef_writes   = 0;
   int ignored_writes = 0;
   int cfg_writes    = 0;

   cascaded_biquad_equalizer_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_sample          (req_sample),
      .req_stage_index     (req_stage_index),
      .req_coef_index      (req_coef_index),
      .req_coef_value      (req_coef_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data)
   );

   always #6 clock = ~clock;

   initial begin
      #12_000_000;
      $display("tb_top failed");
      $finish;
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Run one sample through the active stages, updating history like the block
   function automatic logic signed [SAMPLE_W-1:0] equalize_sample(
         input logic signed [SAMPLE_W-1:0] audio);
      logic signed [SAMPLE_W-1:0] v;
      logic signed [SAMPLE_W-1:0] y;
      longint acc;
      int n;
      int base;
      v = audio;
      n = (int'(stages_cfg) > MAX_STAGES) ? MAX_STAGES : int'(stages_cfg);
      for (int st = 0; st < n; st++) begin
         base = st * COEFS_PER_STAGE;
         acc = longint'(coef_mirror[base + int'(COEF_B0)]) * longint'(v)
             + longint'(coef_mirror[base + int'(COEF_B1)]) * longint'(hist_x1[st])
             + longint'(coef_mirror[base + int'(COEF_B2)]) * longint'(hist_x2[st])
             - longint'(coef_mirror[base + int'(COEF_A1)]) * longint'(hist_y1[st])
             - longint'(coef_mirror[base + int'(COEF_A2)]) * longint'(hist_y2[st]);
         // round half up to Q1.23, then clamp
         acc = (acc + RND_HALF) >>> FRAC_SHIFT;
         if (acc > longint'(SAT_HI)) y = SAT_HI;
         else if (acc < longint'(SAT_LO)) y = SAT_LO;
         else y = acc[SAMPLE_W-1:0];
         hist_x2[st] = hist_x1[st];
         hist_x1[st] = v;
         hist_y2[st] = hist_y1[st];
         hist_y1[st] = y;
         v = y;
      end
      return v;
   endfunction

   // Predictor update for one accepted word
   task automatic apply_word(input eq_word_type w);
      if (w.kind == REQ_SAMPLE) begin
         pending_outputs.push_back(equalize_sample(w.audio));
         samples_sent++;
      end else begin
         coef_writes++;
         if (w.coef_sel <= COEF_A2 && int'(w.stage) < MAX_STAGES)
            coef_mirror[int'(w.stage) * COEFS_PER_STAGE + int'(w.coef_sel)] = w.coef_val;
         else
            ignored_writes++;
      end
   endtask

   function automatic eq_word_type sample_word(input logic signed [SAMPLE_W-1:0] audio);
      eq_word_type w;
      w.kind     = REQ_SAMPLE;
      w.audio    = audio;
      w.stage    = STAGE_IDX_W'($urandom);
      w.coef_sel = COEF_IDX_W'($urandom);
      w.coef_val = $urandom;
      return w;
   endfunction

   function automatic eq_word_type coef_word(input int stage,
                                             input logic [COEF_IDX_W-1:0] sel,
                                             input logic signed [COEF_W-1:0] val);
      eq_word_type w;
      w.kind     = REQ_COEF;
      w.audio    = SAMPLE_W'($urandom);
      w.stage    = STAGE_IDX_W'(stage);
      w.coef_sel = sel;
      w.coef_val = val;
      return w;
   endfunction

   // Mostly gentle taps so the cascade stays stable; now and then any value
   function automatic logic signed [COEF_W-1:0] pick_coef(input logic [COEF_IDX_W-1:0] sel);
      int r;
      if ($urandom_range(0, 9) == 0) return $urandom;
      if (sel == COEF_B0) begin
         r = int'($urandom_range(1 << 29, 1 << 30));
         if ($urandom_range(0, 3) == 0) r = -r;
      end else begin
         r = int'($urandom_range(0, 1 << 28)) - (1 << 27);
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_audio();
      if ($urandom_range(0, 4) == 0) return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
      return SAMPLE_W'($urandom);
   endfunction

   // Send one word; valid stays high afterwards so back-to-back words need no gap
   task automatic send_word(input eq_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= w.kind;
      req_sample      <= w.audio;
      req_stage_index <= w.stage;
      req_coef_index  <= w.coef_sel;
      req_coef_value  <= w.coef_val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_word(w);
   endtask

   // Drop valid, wait for all outputs, then let any write in flight finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_stages(input int count);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= CFG_W'(count);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      stages_cfg = CFG_W'(count);
      cfg_writes++;
   endtask

   // Output checker and receiver stall
   always @(posedge clock) begin : rsp_check
      logic signed [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            note_error($sformatf("unexpected output %0d", rsp_filtered_sample));
         end else begin
            want = pending_outputs.pop_front();
            outputs_seen++;
            if (rsp_filtered_sample !== want)
               note_error($sformatf("output %0d: expected %0d, got %0d",
                                    outputs_seen, want, rsp_filtered_sample));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Zero stages: samples come back unchanged
   task automatic test_passthrough();
      set_stages(0);
      send_word(sample_word(24'sd0));
      send_word(sample_word(SAT_HI));
      send_word(sample_word(SAT_LO));
      send_word(sample_word(24'sd1));
      send_word(sample_word(-24'sd1));
   endtask

   // One stage: identity, bad coefficient slots, saturation, rounding
   task automatic test_single_stage();
      send_word(coef_word(0, COEF_B0, Q_ONE));
      send_word(coef_word(0, COEF_B1, '0));
      send_word(coef_word(0, COEF_B2, '0));
      send_word(coef_word(0, COEF_A1, '0));
      send_word(coef_word(0, COEF_A2, '0));
      // slots past a2 must be dropped
      send_word(coef_word(0, 3'd5, $urandom));
      send_word(coef_word(0, 3'd6, $urandom));
      send_word(coef_word(0, 3'd7, $urandom));
      set_stages(1);
      send_word(sample_word(SAT_HI));
      send_word(sample_word(SAT_LO));
      send_word(sample_word(24'sh12_3456));
      // gain near +2 and -2 clips both ways
      send_word(coef_word(0, COEF_B0, 32'sh7FFF_FFFF));
      send_word(sample_word(SAT_HI));
      send_word(sample_word(SAT_LO));
      send_word(coef_word(0, COEF_B0, 32'sh8000_0000));
      send_word(sample_word(SAT_LO));
      // gain 0.5: exact halves round up
      send_word(coef_word(0, COEF_B0, 32'sh2000_0000));
      send_word(sample_word(24'sd1));
      send_word(sample_word(-24'sd1));
   endtask

   task automatic test_load_all_stages();
      for (int st = 0; st < MAX_STAGES; st++)
         for (int c = int'(COEF_B0); c <= int'(COEF_A2); c++)
            send_word(coef_word(st, COEF_IDX_W'(c), pick_coef(COEF_IDX_W'(c))));
   endtask

   // Full cascade, and counts past the stage limit that must clamp
   task automatic test_stage_extremes();
      set_stages(MAX_STAGES);
      repeat (8) send_word(sample_word(pick_audio()));
      set_stages(31);
      repeat (8) send_word(sample_word(pick_audio()));
      set_stages(MAX_STAGES + 1);
      repeat (4) send_word(sample_word(pick_audio()));
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      logic [COEF_IDX_W-1:0] sel;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int setting = 0; setting < 2; setting++) begin
         set_stages((setting == 0) ? $urandom_range(1, 4) : $urandom_range(0, 31));
         repeat (55) begin
            if ($urandom_range(0, 99) < 85) begin
               send_word(sample_word(pick_audio()));
            end else begin
               sel = ($urandom_range(0, 9) == 0) ? COEF_IDX_W'($urandom_range(5, 7))
                                                 : COEF_IDX_W'($urandom_range(0, 4));
               send_word(coef_word($urandom_range(0, MAX_STAGES - 1), sel, pick_coef(sel)));
            end
         end
      end
   endtask

   initial begin
      foreach (coef_mirror[i]) coef_mirror[i] = '0;
      for (int st = 0; st < MAX_STAGES; st++) begin
         hist_x1[st] = '0;
         hist_x2[st] = '0;
         hist_y1[st] = '0;
         hist_y2[st] = '0;
      end
      stages_cfg    = '0;
      send_idle_pct = 23;
      recv_idle_pct = 53;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_passthrough();
      test_single_stage();
      test_load_all_stages();
      test_stage_extremes();
      test_random_traffic(23, 53);
      test_random_traffic(53, 23);
      test_random_traffic(0, 0);
      settle();

      $display("covered %0d filtered samples and %0d coefficient writes (%0d dropped)",
               samples_sent, coef_writes, ignored_writes);
      $display("across %0d stage-count settings and three idle patterns; %0d errors",
               cfg_writes, error_count);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
